// File: design/ffd_pkg.sv
// shared types, constants and control program of the fractional feedback delay
package ffd_pkg;

   localparam int RING_DEPTH    = 4096;
   localparam int CHANNEL_SLOTS = 4;
   localparam int SAMPLE_WIDTH  = 16;

   localparam int CH_W      = $clog2(CHANNEL_SLOTS);
   localparam int IDX_W     = $clog2(RING_DEPTH);
   localparam int LEN_W     = IDX_W + 1;
   localparam int MEM_DEPTH = RING_DEPTH * CHANNEL_SLOTS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int WHOLE_W   = 12;
   localparam int FRAC_W    = 8;
   localparam int GAIN_W    = 16;
   localparam int CHANS_W   = 3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [GAIN_W-1:0]  GAIN_ONE     = 16'd32768;
   localparam logic [LEN_W-1:0]   RST_LENGTH   = LEN_W'(RING_DEPTH);
   localparam logic [CHANS_W-1:0] RST_CHANNELS = 3'd2;
   localparam logic [WHOLE_W-1:0] RST_WHOLE    = 12'd100;
   localparam logic [FRAC_W-1:0]  RST_FRAC     = 8'd0;
   localparam logic [GAIN_W-1:0]  RST_GAIN     = 16'd16384;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_RD_LO,
      MEM_RD_HI
   } mem_op_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI,
      MUL_MIX
   } mul_op_type;

   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_CLEAR_BUSY,
      JC_NO_REQ,
      JC_INACTIVE,
      JC_OUT_FULL
   } jump_cond_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_CLEAR = 4'd0;
   localparam step_type ST_WAIT  = 4'd1;
   localparam step_type ST_CHECK = 4'd2;
   localparam step_type ST_RDHI  = 4'd3;
   localparam step_type ST_MULHI = 4'd4;
   localparam step_type ST_DLY   = 4'd5;
   localparam step_type ST_MIX   = 4'd6;
   localparam step_type ST_WB    = 4'd7;
   localparam step_type ST_ADV   = 4'd8;

   typedef struct packed {
      mem_op_type mem_op;
      mul_op_type mul_op;
      logic       load_dly;
      logic       emit;
   } dp_ctl_type;

   typedef struct packed {
      dp_ctl_type    dp;
      logic          accept;
      logic          advance;
      jump_cond_type cond;
      step_type      target;
   } ctl_word_type;

   // control store: one word per step
   function automatic ctl_word_type ffd_ucode(input step_type step);
      ctl_word_type w;
      w = '0;
      w.dp.mem_op = MEM_NONE;
      w.dp.mul_op = MUL_NONE;
      w.cond      = JC_NONE;
      w.target    = ST_WAIT;
      unique case (step)
         ST_CLEAR: begin
            w.dp.mem_op = MEM_CLEAR;
            w.cond      = JC_CLEAR_BUSY;
            w.target    = ST_CLEAR;
         end
         ST_WAIT: begin
            w.accept = 1'b1;
            w.cond   = JC_NO_REQ;
            w.target = ST_WAIT;
         end
         ST_CHECK: begin
            w.dp.mem_op = MEM_RD_LO;
            w.cond      = JC_INACTIVE;
            w.target    = ST_ADV;
         end
         ST_RDHI: begin
            w.dp.mem_op = MEM_RD_HI;
            w.dp.mul_op = MUL_LO;
         end
         ST_MULHI: begin
            w.dp.mul_op = MUL_HI;
         end
         ST_DLY: begin
            w.dp.load_dly = 1'b1;
         end
         ST_MIX: begin
            w.dp.mul_op = MUL_MIX;
         end
         ST_WB: begin
            w.dp.emit = 1'b1;
            w.cond    = JC_OUT_FULL;
            w.target  = ST_WB;
         end
         ST_ADV: begin
            w.advance = 1'b1;
            w.cond    = JC_ALWAYS;
            w.target  = ST_WAIT;
         end
         default: begin
            w.cond   = JC_ALWAYS;
            w.target = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// File: design/ffd_if.sv
// request and response channel interfaces
interface ffd_req_if;
   import ffd_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [CH_W-1:0]                channel;
   logic signed [SAMPLE_WIDTH-1:0] in_sample;
   logic                           frame_last;

   modport source(output valid, channel, in_sample, frame_last, input ready);
   modport sink(input valid, channel, in_sample, frame_last, output ready);
endinterface

interface ffd_rsp_if;
   import ffd_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [CH_W-1:0]                out_channel;
   logic signed [SAMPLE_WIDTH-1:0] out_sample;

   modport source(output valid, out_channel, out_sample, input ready);
   modport sink(input valid, out_channel, out_sample, output ready);
endinterface

// File: design/ffd_datapath.sv
// delay store, interpolation and mix arithmetic driven by the control word
module ffd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ffd_pkg::dp_ctl_type                    dp,
   input  logic [ffd_pkg::CH_W-1:0]               channel,
   input  logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] dry,
   input  logic [ffd_pkg::IDX_W-1:0]              lo_idx,
   input  logic [ffd_pkg::IDX_W-1:0]              hi_idx,
   input  logic [ffd_pkg::IDX_W-1:0]              head_idx,
   input  logic [ffd_pkg::FRAC_W-1:0]             frac,
   input  logic [ffd_pkg::GAIN_W-1:0]             mix_gain,
   input  logic [ffd_pkg::GAIN_W-1:0]             feedback_gain,
   output logic                                   clear_last,
   output logic signed [ffd_pkg::SAMPLE_WIDTH-1:0] mix_sample
);
   import ffd_pkg::*;

   localparam int SW      = SAMPLE_WIDTH;
   localparam int WPROD_W = SW + FRAC_W + 1;
   localparam int GPROD_W = SW + GAIN_W + 1;
   localparam int RND_W   = GPROD_W + 1 - 15;
   localparam int SAT_W   = RND_W + 1;

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 <<< (SW - 1)) - 1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
      logic signed [SW-1:0] r;
      r = v[SW-1:0];
      if (v > SAT_HI) begin
         r = SAT_HI[SW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SW-1:0];
      end
      return r;
   endfunction

   logic signed [SW-1:0] store_mem [0:MEM_DEPTH-1];
   logic signed [SW-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    clr_cnt_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic signed [SW-1:0] wr_data;

   logic signed [WPROD_W-1:0] pa_ff, pb_ff;
   logic signed [GPROD_W-1:0] pd_ff, pm_ff, pf_ff;
   logic signed [SW-1:0]      delayed_ff;

   // weights reach 256, so they carry two bits above the fraction
   logic signed [FRAC_W+1:0]  w_lo;
   logic signed [FRAC_W+1:0]  w_hi;
   logic signed [GAIN_W:0]    dry_w;
   logic signed [GAIN_W:0]    mix_w;
   logic signed [GAIN_W:0]    fb_w;
   logic signed [WPROD_W:0]   isum;
   logic signed [GPROD_W:0]   msum;
   logic signed [GPROD_W:0]   fsum;
   logic signed [SAT_W-1:0]   fb_total;
   logic signed [SW-1:0]      fb_sat;

   always_comb begin
      w_lo  = $signed({2'b00, frac});
      w_hi  = $signed((FRAC_W + 2)'(1 << FRAC_W) - {2'b00, frac});
      dry_w = $signed({1'b0, GAIN_ONE} - {1'b0, mix_gain});
      mix_w = $signed({1'b0, mix_gain});
      fb_w  = $signed({1'b0, feedback_gain});

      // round half up, then drop the fraction bits
      isum = (WPROD_W + 1)'(pa_ff) + (WPROD_W + 1)'(pb_ff)
           + (WPROD_W + 1)'(1 << (FRAC_W - 1));
      msum = (GPROD_W + 1)'(pd_ff) + (GPROD_W + 1)'(pm_ff) + (GPROD_W + 1)'(1 << 14);
      fsum = (GPROD_W + 1)'(pf_ff) + (GPROD_W + 1)'(1 << 14);

      mix_sample = sat_sample(SAT_W'($signed(msum[GPROD_W:15])));
      fb_total   = SAT_W'(dry) + SAT_W'($signed(fsum[GPROD_W:15]));
      fb_sat     = sat_sample(fb_total);

      rd_addr = (dp.mem_op == MEM_RD_HI) ? {channel, hi_idx} : {channel, lo_idx};
      wr_en   = (dp.mem_op == MEM_CLEAR) || dp.emit;
      wr_addr = (dp.mem_op == MEM_CLEAR) ? clr_cnt_ff : {channel, head_idx};
      wr_data = (dp.mem_op == MEM_CLEAR) ? '0 : fb_sat;
   end

   assign clear_last = (clr_cnt_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (dp.mem_op == MEM_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      unique case (dp.mul_op)
         MUL_LO: begin
            pa_ff <= WPROD_W'(rd_data_ff) * WPROD_W'(w_lo);
            pd_ff <= GPROD_W'(dry) * GPROD_W'(dry_w);
         end
         MUL_HI: begin
            pb_ff <= WPROD_W'(rd_data_ff) * WPROD_W'(w_hi);
         end
         MUL_MIX: begin
            pm_ff <= GPROD_W'(delayed_ff) * GPROD_W'(mix_w);
            pf_ff <= GPROD_W'(delayed_ff) * GPROD_W'(fb_w);
         end
         default: begin
         end
      endcase
      if (dp.load_dly) begin
         delayed_ff <= isum[SW+FRAC_W-1:FRAC_W];
      end
   end

endmodule

// File: design/fractional_feedback_delay_core.sv
// fractional feedback delay: an accepted request goes through steps CHECK, RDHI, MULHI,
// DLY, MIX and WB into the result register, holding in WB while that register stays full,
// then ADV; an inactive channel goes from CHECK to ADV; the pace is set by the control
// program stepping one word per cycle, save while a step holds, around the delay store
// reset is synchronous: registers return to their defaults and a pass over all 16384
// words clears the delay store with req ready low; register writes are taken meanwhile
module fractional_feedback_delay_core (
   input  logic                            clock,
   input  logic                            reset,
   ffd_req_if.sink                         req_bus,
   ffd_rsp_if.source                       rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ffd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ffd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ffd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ffd_pkg::*;

   typedef enum logic [2:0] {
      REG_RING_LENGTH,
      REG_CHANNELS,
      REG_DELAY_WHOLE,
      REG_DELAY_FRAC,
      REG_FEEDBACK,
      REG_MIX
   } reg_index_type;

   localparam int D_W = WHOLE_W + FRAC_W;

   // configuration
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CHANS_W-1:0] chans_ff, chans_in;
   logic [WHOLE_W-1:0] whole_ff, whole_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [GAIN_W-1:0]  fbg_ff, fbg_in;
   logic [GAIN_W-1:0]  mixg_ff, mixg_in;
   logic               cfg_wr;
   logic               len_change;
   reg_index_type      reg_idx;

   logic [LEN_W-1:0]   len_sat;
   logic [CHANS_W-1:0] chans_sat;
   logic [GAIN_W-1:0]  fbg_sat;
   logic [GAIN_W-1:0]  mixg_sat;

   // derived delay and tap indices
   logic [IDX_W-1:0]   w_ff, w_in;
   logic [FRAC_W-1:0]  f_ff, f_in;
   logic [LEN_W-1:0]   len_m1;
   logic [D_W-1:0]     d_req;
   logic [D_W-1:0]     d_max;
   logic [LEN_W-1:0]   t_hi, t_lo;
   logic [IDX_W-1:0]   hi_idx_ff, hi_idx_in;
   logic [IDX_W-1:0]   lo_idx_ff, lo_idx_in;

   // head
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [LEN_W-1:0]   head_plus;

   // sequencer
   step_type           step_ff, step_in;
   ctl_word_type       word;
   dp_ctl_type         dp_go;
   logic               take;
   logic               clear_last;
   logic               inactive;
   logic               out_full;
   logic               req_go;

   // captured request
   logic [CH_W-1:0]                ch_ff;
   logic signed [SAMPLE_WIDTH-1:0] dry_ff;
   logic                           last_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [CH_W-1:0]                rsp_ch_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] mix_sample;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      len_sat = csr_pwdata[LEN_W-1:0];
      if (len_sat < LEN_W'(2)) begin
         len_sat = LEN_W'(2);
      end else if (len_sat > LEN_W'(RING_DEPTH)) begin
         len_sat = LEN_W'(RING_DEPTH);
      end
      chans_sat = csr_pwdata[CHANS_W-1:0];
      if (chans_sat < CHANS_W'(1)) begin
         chans_sat = CHANS_W'(1);
      end else if (chans_sat > CHANS_W'(CHANNEL_SLOTS)) begin
         chans_sat = CHANS_W'(CHANNEL_SLOTS);
      end
      fbg_sat  = (csr_pwdata[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : csr_pwdata[GAIN_W-1:0];
      mixg_sat = (csr_pwdata[GAIN_W-1:0] > GAIN_ONE) ? GAIN_ONE : csr_pwdata[GAIN_W-1:0];
   end

   always_comb begin
      len_in     = len_ff;
      chans_in   = chans_ff;
      whole_in   = whole_ff;
      frac_in    = frac_ff;
      fbg_in     = fbg_ff;
      mixg_in    = mixg_ff;
      len_change = 1'b0;
      if (cfg_wr) begin
         unique case (reg_idx)
            REG_RING_LENGTH: begin
               len_in     = len_sat;
               len_change = (len_sat != len_ff);
            end
            REG_CHANNELS:    chans_in = chans_sat;
            REG_DELAY_WHOLE: whole_in = csr_pwdata[WHOLE_W-1:0];
            REG_DELAY_FRAC:  frac_in  = csr_pwdata[FRAC_W-1:0];
            REG_FEEDBACK:    fbg_in   = fbg_sat;
            REG_MIX:         mixg_in  = mixg_sat;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_RING_LENGTH: csr_prdata = CSR_DATA_W'(len_ff);
         REG_CHANNELS:    csr_prdata = CSR_DATA_W'(chans_ff);
         REG_DELAY_WHOLE: csr_prdata = CSR_DATA_W'(whole_ff);
         REG_DELAY_FRAC:  csr_prdata = CSR_DATA_W'(frac_ff);
         REG_FEEDBACK:    csr_prdata = CSR_DATA_W'(fbg_ff);
         REG_MIX:         csr_prdata = CSR_DATA_W'(mixg_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // delay saturated to (length - 1) whole samples, fraction then dropped
   always_comb begin
      len_m1 = len_in - LEN_W'(1);
      d_req  = {whole_in, frac_in};
      d_max  = {len_m1[IDX_W-1:0], FRAC_W'(0)};
      if (d_req > d_max) begin
         w_in = len_m1[IDX_W-1:0];
         f_in = '0;
      end else begin
         w_in = whole_in;
         f_in = frac_in;
      end
   end

   // tap indices wrap once at most since the delay stays below the length
   always_comb begin
      t_hi      = {1'b0, head_ff} + len_ff - {1'b0, w_ff};
      t_lo      = t_hi - LEN_W'(f_ff != '0);
      hi_idx_in = (t_hi >= len_ff) ? IDX_W'(t_hi - len_ff) : t_hi[IDX_W-1:0];
      lo_idx_in = (t_lo >= len_ff) ? IDX_W'(t_lo - len_ff) : t_lo[IDX_W-1:0];
   end

   always_comb begin
      head_plus = {1'b0, head_ff} + LEN_W'(1);
      head_in   = head_ff;
      if (len_change) begin
         head_in = '0;
      end else if (word.advance && last_ff) begin
         head_in = (head_plus == len_ff) ? '0 : head_plus[IDX_W-1:0];
      end
   end

   // sequencer
   assign word     = ffd_ucode(step_ff);
   assign inactive = ({1'b0, ch_ff} >= chans_ff);
   assign out_full = rsp_valid_ff && !rsp_bus.ready;
   assign req_go   = req_bus.valid && word.accept;

   always_comb begin
      unique case (word.cond)
         JC_NONE:       take = 1'b0;
         JC_ALWAYS:     take = 1'b1;
         JC_CLEAR_BUSY: take = !clear_last;
         JC_NO_REQ:     take = !req_bus.valid;
         JC_INACTIVE:   take = inactive;
         JC_OUT_FULL:   take = out_full;
         default:       take = 1'b1;
      endcase
      step_in = take ? word.target : step_ff + STEP_W'(1);

      dp_go      = word.dp;
      dp_go.emit = word.dp.emit && !out_full;
   end

   assign req_bus.ready       = word.accept;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.out_sample  = rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= RST_LENGTH;
         chans_ff     <= RST_CHANNELS;
         whole_ff     <= RST_WHOLE;
         frac_ff      <= RST_FRAC;
         fbg_ff       <= RST_GAIN;
         mixg_ff      <= RST_GAIN;
         w_ff         <= RST_WHOLE;
         f_ff         <= RST_FRAC;
         head_ff      <= '0;
         step_ff      <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         chans_ff <= chans_in;
         whole_ff <= whole_in;
         frac_ff  <= frac_in;
         fbg_ff   <= fbg_in;
         mixg_ff  <= mixg_in;
         w_ff     <= w_in;
         f_ff     <= f_in;
         head_ff  <= head_in;
         step_ff  <= step_in;
         if (dp_go.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_idx_ff <= hi_idx_in;
      lo_idx_ff <= lo_idx_in;
      if (req_go) begin
         ch_ff   <= req_bus.channel;
         dry_ff  <= req_bus.in_sample;
         last_ff <= req_bus.frame_last;
      end
      if (dp_go.emit) begin
         rsp_ch_ff     <= ch_ff;
         rsp_sample_ff <= mix_sample;
      end
   end

   ffd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .dp            (dp_go),
      .channel       (ch_ff),
      .dry           (dry_ff),
      .lo_idx        (lo_idx_ff),
      .hi_idx        (hi_idx_ff),
      .head_idx      (head_ff),
      .frac          (f_ff),
      .mix_gain      (mixg_ff),
      .feedback_gain (fbg_ff),
      .clear_last    (clear_last),
      .mix_sample    (mix_sample)
   );

   a_head_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < len_ff)
      else $error("write head outside ring");

   a_delay_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, w_ff} < len_ff)
      else $error("saturated delay not below ring length");

   a_emit_active: assert property (@(posedge clock) disable iff (reset)
      dp_go.emit |-> !inactive)
      else $error("result produced for inactive channel");

   a_head_moves: assert property (@(posedge clock) disable iff (reset)
      !word.advance && !cfg_wr |=> $stable(head_ff))
      else $error("write head moved outside advance step");

endmodule
